// File: sv/sstv_line_chroma_to_rgb_core_macros.svh
// ----------------------------------------------------------------------------
// sstv line chroma to rgb: assertion macros
// Concurrent assertion helpers on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SSTV_LINE_CHROMA_TO_RGB_CORE_MACROS_SVH
`define SSTV_LINE_CHROMA_TO_RGB_CORE_MACROS_SVH

`ifndef SYNTH

// property that must hold at every edge
`define SLCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define SLCR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define SLCR_ASSERT(lbl, prop, msg)

`define SLCR_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// File: sv/slcr_pkg.sv
// ----------------------------------------------------------------------------
// slcr_pkg
// Shared constants, types and the clamp function of the chroma-to-rgb core.
// ----------------------------------------------------------------------------
`default_nettype none

package slcr_pkg;

  // configuration register indexes
  localparam logic REG_FULL_COLOR = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;

  localparam int unsigned CFG_W = 10;
  localparam int unsigned LW_W  = 10;
  localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 10'd320;

  // fixed-point bt.601 inverse, scaled by 1024
  localparam logic signed [12:0] COEF_Y    = 13'sd1192;
  localparam logic signed [12:0] COEF_R_CR = 13'sd1634;
  localparam logic signed [12:0] COEF_G_CB = 13'sd401;
  localparam logic signed [12:0] COEF_G_CR = 13'sd833;
  localparam logic signed [12:0] COEF_B_CB = 13'sd2066;

  localparam logic [8:0] LUMA_OFS   = 9'd16;
  localparam logic [8:0] CHROMA_OFS = 9'd128;
  localparam logic [7:0] CHROMA_MID = 8'd128;

  localparam int unsigned PROD_W = 22;
  localparam int unsigned ACC_W  = 23;
  localparam int unsigned FRAC_W = 10;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // pixel as it enters the color matrix
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cr;
    logic [7:0] cb;
    logic       last;
  } pix_t;

  // finished pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
  } rgb_t;

  // floor shift by the fraction width, then clamp to 0..255
  function automatic logic [7:0] clamp_shift(input acc_t acc);
    logic [ACC_W-2-FRAC_W:0] shifted;
    shifted = acc[ACC_W-2:FRAC_W];
    if (acc[ACC_W-1]) begin
      return 8'd0;
    end else if (|shifted[ACC_W-2-FRAC_W:8]) begin
      return 8'd255;
    end else begin
      return shifted[7:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/slcr_line_store.sv
// ----------------------------------------------------------------------------
// slcr_line_store
// Two single-port-write, registered-read line memories for Cr and Cb.
// ----------------------------------------------------------------------------
`default_nettype none

module slcr_line_store #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic          wr_cr_i,
  input  wire logic          wr_cb_i,
  input  wire logic [7:0]    wdata_i,
  output logic [7:0]         rd_cr_o,
  output logic [7:0]         rd_cb_o
);

  logic [7:0] cr_mem [DEPTH];
  logic [7:0] cb_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_cr_i) begin
      cr_mem[addr_i] <= wdata_i;
    end
    if (wr_cb_i) begin
      cb_mem[addr_i] <= wdata_i;
    end
  end

  // read data holds while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_cr_o <= cr_mem[addr_i];
      rd_cb_o <= cb_mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/slcr_color_matrix.sv
// ----------------------------------------------------------------------------
// slcr_color_matrix
// Two-stage ycbcr to rgb matrix: products, then sums with clamp into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slcr_color_matrix (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire slcr_pkg::pix_t in_pix_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output slcr_pkg::rgb_t     out_rgb_o
);

  logic signed [8:0] c_s, d_s, e_s;

  slcr_pkg::prod_t py_q, pr_q, pgd_q, pge_q, pb_q;
  logic            last2_q;
  logic            v2_q, v3_q;
  logic            rdy2, rdy3;

  slcr_pkg::acc_t  r_acc, g_acc, b_acc;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = rdy2;

  assign c_s = $signed({1'b0, in_pix_i.luma} - slcr_pkg::LUMA_OFS);
  assign d_s = $signed({1'b0, in_pix_i.cb} - slcr_pkg::CHROMA_OFS);
  assign e_s = $signed({1'b0, in_pix_i.cr} - slcr_pkg::CHROMA_OFS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= in_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      py_q    <= slcr_pkg::PROD_W'(c_s) * slcr_pkg::PROD_W'(slcr_pkg::COEF_Y);
      pr_q    <= slcr_pkg::PROD_W'(e_s) * slcr_pkg::PROD_W'(slcr_pkg::COEF_R_CR);
      pgd_q   <= slcr_pkg::PROD_W'(d_s) * slcr_pkg::PROD_W'(slcr_pkg::COEF_G_CB);
      pge_q   <= slcr_pkg::PROD_W'(e_s) * slcr_pkg::PROD_W'(slcr_pkg::COEF_G_CR);
      pb_q    <= slcr_pkg::PROD_W'(d_s) * slcr_pkg::PROD_W'(slcr_pkg::COEF_B_CB);
      last2_q <= in_pix_i.last;
    end
  end

  assign r_acc = slcr_pkg::ACC_W'(py_q) + slcr_pkg::ACC_W'(pr_q);
  assign g_acc = slcr_pkg::ACC_W'(py_q) - slcr_pkg::ACC_W'(pgd_q) - slcr_pkg::ACC_W'(pge_q);
  assign b_acc = slcr_pkg::ACC_W'(py_q) + slcr_pkg::ACC_W'(pb_q);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      out_rgb_o.red     <= slcr_pkg::clamp_shift(r_acc);
      out_rgb_o.green   <= slcr_pkg::clamp_shift(g_acc);
      out_rgb_o.blue    <= slcr_pkg::clamp_shift(b_acc);
      out_rgb_o.row_end <= last2_q;
    end
  end

  assign out_valid_o = v3_q;

endmodule

`default_nettype wire

// File: sv/sstv_line_chroma_to_rgb_core.sv
// One pixel column per transaction in, one 8-bit RGB pixel per transaction out, in order.
// The core sustains one pixel per clock as long as the output is not held off. A pixel sits
// in three register stages: line store read, matrix products, then sum and clamp, the last
// being the output register, from which it leaves when m_axis_tready is high. Each pixel
// reads both line memories and, in alternating mode, writes one of them. In alternating
// mode the missing chroma is read from the line written on the previous line of the other
// parity, and reads as neutral 128 until that memory has been written once. The memories
// need no clearing pass after reset. Configuration registers: index 0 full_color, index 1
// line_width (0 acts as 1, above MAX_WIDTH acts as MAX_WIDTH); write them only while no
// pixel is in flight.
`default_nettype none

module sstv_line_chroma_to_rgb_core #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration write port
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [slcr_pkg::CFG_W-1:0] cfg_data_i,
  // pixel column in
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [23:0]                s_axis_tdata,  // luma_level, chroma_first, chroma_second
  // rgb pixel out
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // red, green, blue
  output logic                            m_axis_tlast   // row_end
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CW    = (COL_W + 1 > slcr_pkg::LW_W + 1) ? COL_W + 1
                                                                   : slcr_pkg::LW_W + 1;
  localparam logic [CW-1:0] MAX_EXT = CW'(MAX_WIDTH);

  // configuration
  logic                      full_color_q;
  logic [slcr_pkg::LW_W-1:0] line_width_q;

  // line position and store flags
  logic [COL_W-1:0] col_q, col_d;
  logic             odd_q, odd_d;
  logic             cr_present_q, cr_present_d;
  logic             cb_present_q, cb_present_d;

  logic [CW-1:0] lw_ext, width_eff, col_next;
  logic          last;
  logic          accept;
  logic          wr_cr, wr_cb;

  logic [7:0] luma_in, first_in, second_in;

  // stage 1: waiting for line store read data
  logic       v1_q;
  logic [7:0] luma1_q, first1_q, second1_q;
  logic       full1_q, odd1_q, crp1_q, cbp1_q, last1_q;
  logic       rdy1;

  logic [7:0] rd_cr, rd_cb;

  slcr_pkg::pix_t mx_pix;
  slcr_pkg::rgb_t mx_rgb;
  logic           mx_ready;

  assign luma_in   = s_axis_tdata[7:0];
  assign first_in  = s_axis_tdata[15:8];
  assign second_in = s_axis_tdata[23:16];

  assign rdy1          = !v1_q || mx_ready;
  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_color_q <= 1'b0;
      line_width_q <= slcr_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        slcr_pkg::REG_FULL_COLOR: full_color_q <= cfg_data_i[0];
        slcr_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data_i[slcr_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lw_ext = CW'(line_width_q);
    if (lw_ext == '0) begin
      width_eff = CW'(1);
    end else if (lw_ext > MAX_EXT) begin
      width_eff = MAX_EXT;
    end else begin
      width_eff = lw_ext;
    end
  end

  // a lowered width ends the line on this pixel when the column is past it
  assign col_next = CW'(col_q) + CW'(1);
  assign last     = (col_next >= width_eff);

  assign wr_cr = accept && !full_color_q && !odd_q;
  assign wr_cb = accept && !full_color_q && odd_q;

  always_comb begin
    col_d        = col_q;
    odd_d        = odd_q;
    cr_present_d = cr_present_q || wr_cr;
    cb_present_d = cb_present_q || wr_cb;
    if (accept) begin
      if (last) begin
        col_d = '0;
        odd_d = !odd_q;
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      odd_q        <= 1'b0;
      cr_present_q <= 1'b0;
      cb_present_q <= 1'b0;
      v1_q         <= 1'b0;
    end else begin
      col_q        <= col_d;
      odd_q        <= odd_d;
      cr_present_q <= cr_present_d;
      cb_present_q <= cb_present_d;
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      luma1_q   <= luma_in;
      first1_q  <= first_in;
      second1_q <= second_in;
      full1_q   <= full_color_q;
      odd1_q    <= odd_q;
      crp1_q    <= cr_present_q;
      cbp1_q    <= cb_present_q;
      last1_q   <= last;
    end
  end

  // each pixel uses read data only from the memory it does not write, and a later pixel
  // reads only after the write has completed, so no forwarding path is needed
  slcr_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_store (
    .clk_i   (clk_i),
    .rd_en_i (accept),
    .addr_i  (col_q),
    .wr_cr_i (wr_cr),
    .wr_cb_i (wr_cb),
    .wdata_i (first_in),
    .rd_cr_o (rd_cr),
    .rd_cb_o (rd_cb)
  );

  always_comb begin
    mx_pix.luma = luma1_q;
    mx_pix.last = last1_q;
    if (full1_q) begin
      mx_pix.cr = first1_q;
      mx_pix.cb = second1_q;
    end else if (!odd1_q) begin
      mx_pix.cr = first1_q;
      mx_pix.cb = cbp1_q ? rd_cb : slcr_pkg::CHROMA_MID;
    end else begin
      mx_pix.cb = first1_q;
      mx_pix.cr = crp1_q ? rd_cr : slcr_pkg::CHROMA_MID;
    end
  end

  slcr_color_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (mx_ready),
    .in_pix_i    (mx_pix),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rgb_o   (mx_rgb)
  );

  assign m_axis_tdata = {mx_rgb.blue, mx_rgb.green, mx_rgb.red};
  assign m_axis_tlast = mx_rgb.row_end;

`include "sstv_line_chroma_to_rgb_core_macros.svh"

  `SLCR_ASSERT_NEXT(a_line_wraps, accept && last, col_q == '0, "column did not wrap at line end")
  `SLCR_ASSERT_NEXT(a_cr_marked, wr_cr, cr_present_q, "cr store write not recorded")
  `SLCR_ASSERT(a_present_sticky, !$fell(cr_present_q) && !$fell(cb_present_q), "present flag cleared")
  `SLCR_ASSERT(a_stall_source, s_axis_tready || v1_q, "input stalled with empty first stage")

endmodule

`default_nettype wire

// File: sim/tb_sstv_line_chroma_to_rgb_core.sv
// ----------------------------------------------------------------------------
// tb_sstv_line_chroma_to_rgb_core
// Streams pixel columns through the chroma-to-rgb core. A short table of
// directed steps is followed by a warm-up frame and random phases. Each
// phase may set the color mode and the line width while the core is idle.
// Every output pixel is compared with a scoreboard fed by an in-bench predictor.
// Random stalls on both sides, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sstv_line_chroma_to_rgb_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX    = 512;
  localparam int unsigned PIXEL_COUNT = 1400;
  localparam int unsigned QUIET_AFTER = 1300;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
  } rgb_px_t;

  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_CHECKED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        idx;
    logic [9:0]  val;
    logic [7:0]  luma;
    logic [7:0]  chroma_a;
    logic [7:0]  chroma_b;
    rgb_px_t     want;
  } plan_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = 1'b0;
  logic [slcr_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata = '0;  // luma_level, chroma_first, chroma_second
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;       // red, green, blue
  logic             m_axis_tlast;       // row_end

  // predictor state
  logic             full_color_q = 1'b0;
  logic [9:0]       line_width_q = 10'd320;
  int               line_col = 0;
  logic             odd_line = 1'b0;
  logic [7:0]       cr_line_mem [LINE_MAX];
  logic [7:0]       cb_line_mem [LINE_MAX];
  logic             cr_seen = 1'b0;
  logic             cb_seen = 1'b0;

  rgb_px_t          rgb_due [$];
  plan_t            plan [$];
  int               mismatches = 0;
  int               pixels_sent = 0;
  logic             hold_req = 1'b0;
  logic             quiet_tail = 1'b0;

  sstv_line_chroma_to_rgb_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [7:0] clip_channel(input int acc);
    int q;
    if (acc < 0) return 8'd0;
    q = acc >>> 10;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // one pixel through the color matrix, line stores updated as the core does
  function automatic void predict_rgb(input logic [7:0] luma, chroma_a, chroma_b);
    int w, x, cr, cb, c, d, e;
    rgb_px_t px;
    w = line_width_q;
    if (w < 1) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    x = (line_col >= LINE_MAX) ? LINE_MAX - 1 : line_col;
    if (full_color_q) begin
      cr = chroma_a;
      cb = chroma_b;
    end else if (!odd_line) begin
      cr = chroma_a;
      cb = cb_seen ? cb_line_mem[x] : 128;
      cr_line_mem[x] = chroma_a;
      cr_seen = 1'b1;
    end else begin
      cb = chroma_a;
      cr = cr_seen ? cr_line_mem[x] : 128;
      cb_line_mem[x] = chroma_a;
      cb_seen = 1'b1;
    end
    c = int'(luma) - 16;
    d = cb - 128;
    e = cr - 128;
    px.red     = clip_channel(1192 * c + 1634 * e);
    px.green   = clip_channel(1192 * c - 401 * d - 833 * e);
    px.blue    = clip_channel(1192 * c + 2066 * d);
    px.row_end = (x + 1 >= w);
    if (px.row_end) begin
      line_col = 0;
      odd_line = ~odd_line;
    end else begin
      line_col = x + 1;
    end
    rgb_due.push_back(px);
  endfunction

  function automatic plan_t px_row(input logic [7:0] luma, chroma_a, chroma_b);
    plan_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.luma = luma;
    r.chroma_a = chroma_a;
    r.chroma_b = chroma_b;
    return r;
  endfunction

  function automatic plan_t px_known(input logic [7:0] luma, chroma_a, chroma_b,
                                     input logic [7:0] red, green, blue,
                                     input logic row_end);
    plan_t r;
    r = px_row(luma, chroma_a, chroma_b);
    r.kind = ROW_CHECKED;
    r.want = '{red, green, blue, row_end};
    return r;
  endfunction

  function automatic plan_t cfg_row(input logic idx, input logic [9:0] val);
    plan_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // register writes only once every pixel in flight has come out
  task automatic write_reg(input logic idx, input logic [9:0] val);
    s_axis_tvalid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == slcr_pkg::REG_FULL_COLOR) full_color_q = val[0];
    else line_width_q = val;
  endtask

  task automatic send_pixel(input logic [7:0] luma, chroma_a, chroma_b);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {chroma_b, chroma_a, luma};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rgb(luma, chroma_a, chroma_b);
    pixels_sent++;
    if (pixels_sent >= QUIET_AFTER) quiet_tail <= 1'b1;
  endtask

  task automatic send_random_pixel();
    send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  function automatic void cmp_field(input string name, input logic [7:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // output side: checks each transaction, random stalls and one long hold-off
  initial begin : rgb_sink
    int stall_left;
    int hold_left;
    logic hold_taken;
    rgb_px_t want;
    stall_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (rgb_due.size() == 0) begin
          $display("%0t: pixel with nothing expected: tdata %h tlast %b", $time,
                   m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = rgb_due.pop_front();
          cmp_field("red", want.red, m_axis_tdata[7:0]);
          cmp_field("green", want.green, m_axis_tdata[15:8]);
          cmp_field("blue", want.blue, m_axis_tdata[23:16]);
          cmp_field("row_end", {7'd0, want.row_end}, {7'd0, m_axis_tlast});
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (quiet_tail) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : pixel_source
    int phase;
    int burst;
    plan = '{
      // after reset: alternating, even line, no cb line stored yet (neutral)
      px_known(8'd16, 8'd128, 8'hff, 8'd0, 8'd0, 8'd0, 1'b0),
      px_known(8'd255, 8'd128, 8'h00, 8'd255, 8'd255, 8'd255, 1'b0),
      px_known(8'd0, 8'd0, 8'hff, 8'd0, 8'd85, 8'd0, 1'b0),
      px_row(8'd255, 8'd255, 8'd0),
      px_row(8'd128, 8'd64, 8'd170),
      // width 0 acts as 1 and the current column is past it
      cfg_row(slcr_pkg::REG_LINE_WIDTH, 10'd0),
      cfg_row(slcr_pkg::REG_FULL_COLOR, 10'd1),
      px_row(8'd235, 8'd240, 8'd16),
      px_known(8'd16, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1),
      px_row(8'd255, 8'd255, 8'd255),
      px_known(8'd0, 8'd0, 8'd0, 8'd0, 8'd135, 8'd0, 1'b1),
      // oversized width clamps to the line store depth
      cfg_row(slcr_pkg::REG_LINE_WIDTH, 10'd1023),
      px_row(8'd16, 8'd16, 8'd16),
      px_row(8'd235, 8'd240, 8'd240),
      px_row(8'd128, 8'd255, 8'd0),
      px_row(8'd60, 8'd0, 8'd255),
      px_row(8'd180, 8'd128, 8'd200),
      // narrowed below the current column
      cfg_row(slcr_pkg::REG_LINE_WIDTH, 10'd3),
      px_row(8'd200, 8'd90, 8'd30),
      px_row(8'd255, 8'd0, 8'd0),
      px_row(8'd1, 8'd200, 8'd100),
      px_row(8'd90, 8'd170, 8'd85)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_pixel(plan[i].luma, plan[i].chroma_a, plan[i].chroma_b);
        if (plan[i].kind == ROW_CHECKED) rgb_due[$] = plan[i].want;
      end
    end

    // get back to the start of an even line without touching the line stores
    write_reg(slcr_pkg::REG_LINE_WIDTH, 10'd1);
    while (odd_line || line_col != 0) send_random_pixel();

    // one full-width even and odd line, so every line store entry holds data
    write_reg(slcr_pkg::REG_FULL_COLOR, 10'd0);
    write_reg(slcr_pkg::REG_LINE_WIDTH, 10'(LINE_MAX));
    repeat (2 * LINE_MAX) send_random_pixel();

    phase = 0;
    while (pixels_sent < PIXEL_COUNT) begin
      case ($urandom_range(0, 3))
        0: write_reg(slcr_pkg::REG_FULL_COLOR, 10'($urandom_range(0, 1)));
        1: ;
        default: write_reg(slcr_pkg::REG_FULL_COLOR, 10'($urandom_range(0, 1)));
      endcase
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: write_reg(slcr_pkg::REG_LINE_WIDTH, 10'($urandom_range(0, 1023)));
          1: write_reg(slcr_pkg::REG_LINE_WIDTH, 10'(LINE_MAX));
          default: write_reg(slcr_pkg::REG_LINE_WIDTH, 10'($urandom_range(1, 24)));
        endcase
      end
      burst = $urandom_range(8, 40);
      // first phase: sink holds off while pixels keep coming
      if (phase == 0) begin
        hold_req <= 1'b1;
        burst = 120;
      end
      repeat (burst) send_random_pixel();
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
